/* src/binary_msd_radix_sorter_defines.svh */
// ---------------------------------------------------------------------------
// binary_msd_radix_sorter_defines: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BINARY_MSD_RADIX_SORTER_DEFINES_SVH
`define BINARY_MSD_RADIX_SORTER_DEFINES_SVH

`ifndef SYNTHESIS
`define BMRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMRS_ASSERT(lbl, prop, msg)
`define BMRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/bmrs_pkg.sv */
// ---------------------------------------------------------------------------
// bmrs_pkg: shared definitions for the radix sorter
// Default sizes, field widths, request codes and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package bmrs_pkg;

  localparam int MAX_KEYS_DEF = 1024;
  localparam int KEY_BITS_DEF = 32;

  localparam int KEY_FIELD_W = 32;
  localparam int IDX_FIELD_W = 10;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_RD     = 9'b000000010,
    ST_PINIT  = 9'b000000100,
    ST_RFETCH = 9'b000001000,
    ST_RLOAD  = 9'b000010000,
    ST_SCAN   = 9'b000100000,
    ST_RWR1   = 9'b001000000,
    ST_RWR2   = 9'b010000000,
    ST_NEXTR  = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

/* src/bmrs_ram.sv */
// ---------------------------------------------------------------------------
// bmrs_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bmrs_ram
  import bmrs_pkg::*;
#(
  parameter int DEPTH = MAX_KEYS_DEF,
  parameter int WIDTH = KEY_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/binary_msd_radix_sorter.sv */
// ---------------------------------------------------------------------------
// binary_msd_radix_sorter: MSD binary radix sort of a loaded key set
// Load keys, the last one starts the sort, then read keys back by index.
// ---------------------------------------------------------------------------
// Loads are taken back to back while the block is idle. The load that
// carries tlast starts the sort: KEY_BITS passes, each streaming every key
// once through the read port of one key buffer and the write port of the
// other (one key a cycle), with the states RFETCH, RLOAD, SCAN, RWR1 and
// NEXTR around each range for its range records (RWR2 as well when the range
// splits) and PINIT at the start of each pass.
// The block accepts nothing while it sorts. A read request passes through the
// buffer read, then the output register. Reads return ok = 0 until a sort
// has finished or when the index is at or beyond the key count; loads past
// MAX_KEYS are dropped. The buffers need no clearing after reset.
`default_nettype none

`include "binary_msd_radix_sorter_defines.svh"

module binary_msd_radix_sorter
  import bmrs_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // in_tdata: key[31:0], index[41:32], zero fill [47:42]
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: op
  input  wire                    in_tuser,
  input  wire                    in_tlast,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // out_tdata: sorted_key[31:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: ok
  output logic                   out_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready
);

  localparam int AW   = $clog2(MAX_KEYS);
  localparam int CW   = AW + 1;
  localparam int PW   = $clog2(KEY_BITS);
  localparam int CMPW = (CW > IDX_FIELD_W) ? CW : IDX_FIELD_W;
  localparam int XW   = (KEY_BITS > KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam bit RES_IN_B = (KEY_BITS % 2) != 0;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            sorted_r, sorted_nxt;
  logic [CW-1:0]   rtotal_r, rtotal_nxt;
  logic [PW-1:0]   pass_r, pass_nxt;
  logic [AW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   fresh_r, fresh_nxt;
  logic [AW-1:0]   first_r, first_nxt;
  logic [AW-1:0]   final_r, final_nxt;
  logic [AW-1:0]   i_r, i_nxt;
  logic [AW-1:0]   front_r, front_nxt;
  logic [AW-1:0]   back_r, back_nxt;
  logic            hz_r, hz_nxt;
  logic            ho_r, ho_nxt;
  logic            done_r, done_nxt;
  logic            pend_r, pend_nxt;
  logic            ok_r, ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [KEY_FIELD_W-1:0] out_key_r, out_key_nxt;
  logic            out_ok_r, out_ok_nxt;

  logic                a_we, a_re, b_we, b_re;
  logic [AW-1:0]       a_waddr, a_raddr, b_waddr, b_raddr;
  logic [KEY_BITS-1:0] a_wdata, b_wdata, a_rdata, b_rdata;
  logic                r0_we, r0_re, r1_we, r1_re;
  logic [AW-1:0]       r0_waddr, r0_raddr, r1_waddr, r1_raddr;
  logic [2*AW-1:0]     r0_wdata, r1_wdata, r0_rdata, r1_rdata;

  logic                in_acc;
  logic                in_op;
  logic [CMPW-1:0]     idx_x;
  logic [XW-1:0]       key_x;
  logic [KEY_BITS-1:0] key_st;
  logic [KEY_BITS-1:0] src_data;
  logic [KEY_BITS-1:0] res_data;
  logic [XW-1:0]       res_x;
  logic [2*AW-1:0]     rng_rdata;
  logic [PW-1:0]       bit_pos;
  logic [CW-1:0]       base;
  logic [CW-1:0]       cnt_new;
  logic                both;
  logic [AW-1:0]       nx_addr;
  logic [2*AW-1:0]     nx_data;
  logic                nx_we;
  logic                dst_we;
  logic [AW-1:0]       dst_addr;

  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = in_tuser;
  assign idx_x     = CMPW'(in_tdata[KEY_FIELD_W +: IDX_FIELD_W]);
  assign key_x     = XW'(in_tdata[KEY_FIELD_W-1:0]);
  assign key_st    = key_x[KEY_BITS-1:0];
  assign src_data  = pass_r[0] ? b_rdata : a_rdata;
  assign res_data  = RES_IN_B ? b_rdata : a_rdata;
  assign res_x     = XW'(res_data);
  assign rng_rdata = pass_r[0] ? r1_rdata : r0_rdata;
  assign bit_pos   = PW'(KEY_BITS - 1) - pass_r;
  assign both      = hz_r && ho_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_key_r;
  assign out_tuser  = out_ok_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sorted_nxt    = sorted_r;
    rtotal_nxt    = rtotal_r;
    pass_nxt      = pass_r;
    k_nxt         = k_r;
    fresh_nxt     = fresh_r;
    first_nxt     = first_r;
    final_nxt     = final_r;
    i_nxt         = i_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    hz_nxt        = hz_r;
    ho_nxt        = ho_r;
    done_nxt      = done_r;
    pend_nxt      = pend_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_ok_nxt    = out_ok_r;
    base          = '0;
    cnt_new       = '0;

    a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_re = 1'b0; a_raddr = '0;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_re = 1'b0; b_raddr = '0;
    r0_we = 1'b0; r0_waddr = '0; r0_wdata = '0; r0_re = 1'b0; r0_raddr = '0;
    r1_we = 1'b0; r1_waddr = '0; r1_wdata = '0; r1_re = 1'b0; r1_raddr = '0;
    nx_we    = 1'b0;
    nx_addr  = fresh_r[AW-1:0];
    nx_data  = '0;
    dst_we   = 1'b0;
    dst_addr = front_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_READ) begin
            ok_nxt = sorted_r && (idx_x < CMPW'(count_r));
            if (RES_IN_B) begin
              b_re    = 1'b1;
              b_raddr = idx_x[AW-1:0];
            end else begin
              a_re    = 1'b1;
              a_raddr = idx_x[AW-1:0];
            end
            state_nxt = ST_RD;
          end else begin
            base       = sorted_r ? '0 : count_r;
            sorted_nxt = 1'b0;
            cnt_new    = base;
            if (base < CW'(MAX_KEYS)) begin
              a_we    = 1'b1;
              a_waddr = base[AW-1:0];
              a_wdata = key_st;
              cnt_new = base + CW'(1);
            end
            count_nxt = cnt_new;
            if (in_tlast) begin
              r0_we      = 1'b1;
              r0_waddr   = '0;
              r0_wdata   = {AW'(0), AW'(cnt_new - CW'(1))};
              rtotal_nxt = CW'(1);
              fresh_nxt  = '0;
              pass_nxt   = '0;
              state_nxt  = ST_PINIT;
            end
          end
        end
      end
      ST_RD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = ok_r ? res_x[KEY_FIELD_W-1:0] : '0;
          out_ok_nxt    = ok_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_PINIT: begin
        k_nxt     = '0;
        fresh_nxt = '0;
        state_nxt = ST_RFETCH;
      end
      ST_RFETCH: begin
        if (pass_r[0]) begin
          r1_re    = 1'b1;
          r1_raddr = k_r;
        end else begin
          r0_re    = 1'b1;
          r0_raddr = k_r;
        end
        state_nxt = ST_RLOAD;
      end
      ST_RLOAD: begin
        first_nxt = rng_rdata[2*AW-1:AW];
        final_nxt = rng_rdata[AW-1:0];
        i_nxt     = rng_rdata[2*AW-1:AW];
        front_nxt = rng_rdata[2*AW-1:AW];
        back_nxt  = rng_rdata[AW-1:0];
        hz_nxt    = 1'b0;
        ho_nxt    = 1'b0;
        done_nxt  = 1'b0;
        pend_nxt  = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        pend_nxt = 1'b0;
        if (!done_r) begin
          if (pass_r[0]) begin
            b_re    = 1'b1;
            b_raddr = i_r;
          end else begin
            a_re    = 1'b1;
            a_raddr = i_r;
          end
          i_nxt    = i_r + AW'(1);
          done_nxt = (i_r == final_r);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          dst_we = 1'b1;
          if (src_data[bit_pos]) begin
            dst_addr = back_r;
            back_nxt = back_r - AW'(1);
            ho_nxt   = 1'b1;
          end else begin
            dst_addr  = front_r;
            front_nxt = front_r + AW'(1);
            hz_nxt    = 1'b1;
          end
        end
        if (done_r && !pend_r) begin
          state_nxt = ST_RWR1;
        end
      end
      ST_RWR1: begin
        nx_we     = 1'b1;
        nx_data   = {first_r, both ? (front_r - AW'(1)) : final_r};
        fresh_nxt = fresh_r + CW'(1);
        state_nxt = both ? ST_RWR2 : ST_NEXTR;
      end
      ST_RWR2: begin
        nx_we     = 1'b1;
        nx_data   = {front_r, final_r};
        fresh_nxt = fresh_r + CW'(1);
        state_nxt = ST_NEXTR;
      end
      ST_NEXTR: begin
        if (CW'(k_r) + CW'(1) == rtotal_r) begin
          rtotal_nxt = fresh_r;
          if (pass_r == PW'(KEY_BITS - 1)) begin
            sorted_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            pass_nxt  = pass_r + PW'(1);
            state_nxt = ST_PINIT;
          end
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = ST_RFETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // next-pass range records and partition writes go to the other bank
    if (nx_we) begin
      if (pass_r[0]) begin
        r0_we = 1'b1; r0_waddr = nx_addr; r0_wdata = nx_data;
      end else begin
        r1_we = 1'b1; r1_waddr = nx_addr; r1_wdata = nx_data;
      end
    end
    if (dst_we) begin
      if (pass_r[0]) begin
        a_we = 1'b1; a_waddr = dst_addr; a_wdata = src_data;
      end else begin
        b_we = 1'b1; b_waddr = dst_addr; b_wdata = src_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sorted_r    <= 1'b0;
      rtotal_r    <= '0;
      pass_r      <= '0;
      k_r         <= '0;
      fresh_r     <= '0;
      done_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sorted_r    <= sorted_nxt;
      rtotal_r    <= rtotal_nxt;
      pass_r      <= pass_nxt;
      k_r         <= k_nxt;
      fresh_r     <= fresh_nxt;
      done_r      <= done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r   <= first_nxt;
    final_r   <= final_nxt;
    i_r       <= i_nxt;
    front_r   <= front_nxt;
    back_r    <= back_nxt;
    hz_r      <= hz_nxt;
    ho_r      <= ho_nxt;
    ok_r      <= ok_nxt;
    out_key_r <= out_key_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  bmrs_ram #(.DEPTH(MAX_KEYS), .WIDTH(KEY_BITS)) u_buf_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  bmrs_ram #(.DEPTH(MAX_KEYS), .WIDTH(KEY_BITS)) u_buf_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  bmrs_ram #(.DEPTH(MAX_KEYS), .WIDTH(2 * AW)) u_rng_0 (
    .clk(clk), .we(r0_we), .waddr(r0_waddr), .wdata(r0_wdata),
    .re(r0_re), .raddr(r0_raddr), .rdata(r0_rdata)
  );

  bmrs_ram #(.DEPTH(MAX_KEYS), .WIDTH(2 * AW)) u_rng_1 (
    .clk(clk), .we(r1_we), .waddr(r1_waddr), .wdata(r1_wdata),
    .re(r1_re), .raddr(r1_raddr), .rdata(r1_rdata)
  );

  `BMRS_ASSERT(a_sort_done, $rose(sorted_r) |-> $past(state_r == ST_NEXTR), "sort done out of sequence")
  `BMRS_ASSERT(a_out_from_rd, $rose(out_valid_r) |-> $past(state_r == ST_RD), "result without read")
  `BMRS_ASSERT(a_part_room, (state_r == ST_SCAN && pend_r) |-> (front_r <= back_r), "partition overrun")
  `BMRS_ASSERT(a_ranges_le_keys, (state_r != ST_IDLE && state_r != ST_RD) |-> (fresh_r <= count_r), "too many ranges")

endmodule

`default_nettype wire
